@@ rtl/aesd_pkg.sv @@
// ----------------------------------------------------------------------------
// AES-256 block decryption package
// Shared types, constants and byte-level functions for the inverse cipher.
// ----------------------------------------------------------------------------
package aesd_pkg;

    localparam int LAST_ROUND = 14;
    localparam int KEY_SLOTS  = LAST_ROUND + 1;
    localparam int SLOT_W     = $clog2(KEY_SLOTS);

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    typedef struct packed {
        logic        func;
        logic [3:0]  key_round;
        logic [63:0] data_high;
        logic [63:0] data_low;
    } aesd_in_t;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } aesd_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROUND,
        ST_DONE
    } aesd_state_t;

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by x in GF(2^8) with the AES reduction polynomial.
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = a[7] ? ((a << 1) ^ 8'h1B) : (a << 1);
    endfunction

    function automatic logic [7:0] mul9(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
        mul9 = a8 ^ a;
    endfunction

    function automatic logic [7:0] mul11(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
        mul11 = a8 ^ a2 ^ a;
    endfunction

    function automatic logic [7:0] mul13(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
        mul13 = a8 ^ a4 ^ a;
    endfunction

    function automatic logic [7:0] mul14(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
        mul14 = a8 ^ a4 ^ a2;
    endfunction

endpackage

@@ rtl/aes256_block_decrypt.sv @@
// ----------------------------------------------------------------------------
// AES-256 block decryption engine
// Iterative inverse cipher, one round per cycle, round keys held in a memory.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one beat per item. A beat with func = load writes
//   data_high/data_low into round-key slot key_round (slots above the last
//   round are dropped) and gives no result. A beat with func = decrypt runs
//   the inverse cipher and gives one plaintext beat on the m_ channel.
//   All fifteen keys must be loaded before the first decrypt.
//   A decrypt passes through the states INIT, ROUND and DONE before m_valid
//   rises; one round is done per cycle, set by the single read port of the
//   key memory, which delivers one round key per cycle from a registered read.
//   A load beat is taken while the engine is idle.
//   The result sits in an output register; while the receiver stalls, the
//   engine holds that beat and accepts nothing new, and it resumes once the
//   beat is taken. A new item may be accepted in the cycle the result leaves.
//   Reset clears the control state only; the key memory has no reset.
// ----------------------------------------------------------------------------
module aes256_block_decrypt
    import aesd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  aesd_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output aesd_out_t m_data
);

    logic [127:0] key_mem [KEY_SLOTS];
    logic [127:0] key_rd_reg;

    aesd_state_t state_reg, state_next;
    logic [SLOT_W-1:0] rnd_reg, rnd_next;
    logic [SLOT_W-1:0] rd_addr;
    logic [127:0] blk_reg, blk_next;
    logic [127:0] ct_reg;
    logic m_valid_reg, m_valid_next;

    logic acc, is_dec;
    logic [127:0] after_add, sub_out, mix_out;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign acc     = s_valid && s_ready;
    assign is_dec  = s_data.func == FUNC_DECRYPT;

    // Key memory: one write port for load beats, one registered read port.
    always_ff @(posedge aclk) begin
        if (acc && !is_dec && (s_data.key_round <= 4'(LAST_ROUND))) begin
            key_mem[s_data.key_round[SLOT_W-1:0]] <= {s_data.data_high, s_data.data_low};
        end
        key_rd_reg <= key_mem[rd_addr];
    end

    // During a round the read port fetches the key for the following round.
    always_comb begin
        rd_addr = rnd_reg;
        if ((state_reg == ST_IDLE) || (state_reg == ST_DONE)) begin
            rd_addr = SLOT_W'(LAST_ROUND);
        end else if ((state_reg == ST_ROUND) && (rnd_reg != '0)) begin
            rd_addr = rnd_reg - 1'b1;
        end
    end

    // Round datapath: InvShiftRows and InvSubBytes, AddRoundKey, InvMixColumns.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                sub_out[127 - 8*(r*4 + ((c + r) % 4)) -: 8] =
                    INV_SBOX[blk_reg[127 - 8*(r*4 + c) -: 8]];
            end
        end
        after_add = sub_out ^ key_rd_reg;
        for (int c = 0; c < 4; c++) begin
            logic [7:0] b0, b1, b2, b3;
            b0 = after_add[127 - 8*c -: 8];
            b1 = after_add[127 - 8*(4 + c) -: 8];
            b2 = after_add[127 - 8*(8 + c) -: 8];
            b3 = after_add[127 - 8*(12 + c) -: 8];
            mix_out[127 - 8*c -: 8]        = mul14(b0) ^ mul11(b1) ^ mul13(b2) ^ mul9(b3);
            mix_out[127 - 8*(4 + c) -: 8]  = mul9(b0) ^ mul14(b1) ^ mul11(b2) ^ mul13(b3);
            mix_out[127 - 8*(8 + c) -: 8]  = mul13(b0) ^ mul9(b1) ^ mul14(b2) ^ mul11(b3);
            mix_out[127 - 8*(12 + c) -: 8] = mul11(b0) ^ mul13(b1) ^ mul9(b2) ^ mul14(b3);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (acc && is_dec) state_next = ST_INIT;
            ST_INIT:  state_next = ST_ROUND;
            ST_ROUND: if (rnd_reg == '0) state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        rnd_next     = rnd_reg;
        blk_next     = blk_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                rnd_next = SLOT_W'(LAST_ROUND - 1);
            end
            ST_INIT: begin
                // Key LAST_ROUND is on the read port now.
                blk_next = ct_reg ^ key_rd_reg;
            end
            ST_ROUND: begin
                blk_next = (rnd_reg == '0) ? after_add : mix_out;
                rnd_next = rnd_reg - 1'b1;
            end
            ST_DONE: begin
                m_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    // The key for round r is read while the previous round is computed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            rnd_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            rnd_reg     <= (state_reg == ST_INIT) ? SLOT_W'(LAST_ROUND - 1) : rnd_next;
        end
        blk_reg <= blk_next;
        if (acc) begin
            ct_reg <= {s_data.data_high, s_data.data_low};
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_data.plain_high = blk_reg[127:64];
    assign m_data.plain_low  = blk_reg[63:0];

endmodule

@@ rtl/aesd_checker.sv @@
// ----------------------------------------------------------------------------
// AES-256 block decryption port checker
// Port-level properties of the decryption engine, bound to the top level.
// ----------------------------------------------------------------------------
module aesd_checker
    import aesd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input aesd_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input aesd_out_t m_data
);

    // A result beat holds until taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    // Nothing is accepted while a result is stalled.
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    // A decrypt beat keeps the input closed next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.func == FUNC_DECRYPT |=> !s_ready && !m_valid)
        else $error("engine not busy after decrypt beat");

    // A load beat never produces a result.
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.func == FUNC_LOAD && !m_valid |=> !m_valid)
        else $error("result after load beat");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind aes256_block_decrypt aesd_checker u_aesd_checker (.*);
